[design/median_select_up_to_eight_top_macros.svh]
// Assertion macros for the median select top design file
`ifndef MEDIAN_SELECT_UP_TO_EIGHT_TOP_MACROS_SVH
`define MEDIAN_SELECT_UP_TO_EIGHT_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define MSEL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication with a fixed delay in cycles
`define MSEL_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

[design/msel_pkg.sv]
// Constants and types for the median select pipeline
package msel_pkg;

  localparam int MAX_SLOTS  = 8;
  localparam int VALUE_BITS = 16;
  localparam int CNT_BITS   = $clog2(MAX_SLOTS + 1);

  typedef logic [MAX_SLOTS-1:0][VALUE_BITS-1:0] val_arr_t;
  typedef logic [MAX_SLOTS-1:0]                 slot_vec_t;
  typedef logic [MAX_SLOTS-1:0][MAX_SLOTS-1:0]  rank_mat_t;

  // request control carried down the pipe
  typedef struct packed {
    logic                vld;
    logic [CNT_BITS-1:0] cnt;
  } msel_ctl_t;

endpackage

[design/median_select_up_to_eight_top.sv]
// Median select: one request per cycle from start to done.
// Stages: input/count clamp, compare matrix, rank match, output mux.
// busy is never raised; every request with start high is taken.
// done pulses one cycle with median_value; the receiver cannot stall.
// Synchronous reset clears the pipeline valid bits; data registers keep value.
`include "median_select_up_to_eight_top_macros.svh"

module median_select_up_to_eight_top
  import msel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_0,
  input  logic [VALUE_BITS-1:0] value_1,
  input  logic [VALUE_BITS-1:0] value_2,
  input  logic [VALUE_BITS-1:0] value_3,
  input  logic [VALUE_BITS-1:0] value_4,
  input  logic [VALUE_BITS-1:0] value_5,
  input  logic [VALUE_BITS-1:0] value_6,
  input  logic [VALUE_BITS-1:0] value_7,
  input  logic [CNT_BITS-1:0]   valid_count,
  output logic                  done,
  output logic [VALUE_BITS-1:0] median_value
);

  msel_ctl_t           s1_ctl;
  val_arr_t            s1_vals;
  logic [CNT_BITS-1:0] cnt_next;

  logic                sel_vld;
  slot_vec_t           sel;
  val_arr_t            sel_vals;
  logic [VALUE_BITS-1:0] med_next;

  assign busy = 1'b0;

  // zero count acts as one, oversize count saturates
  always_comb begin
    priority if (valid_count == '0) begin
      cnt_next = CNT_BITS'(1);
    end else if (valid_count > CNT_BITS'(MAX_SLOTS)) begin
      cnt_next = CNT_BITS'(MAX_SLOTS);
    end else begin
      cnt_next = valid_count;
    end
  end

  // valid bit resets, count does not
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.vld <= 1'b0;
    end else begin
      s1_ctl.vld <= start && !busy;
    end
    s1_ctl.cnt <= cnt_next;
  end

  always_ff @(posedge clk) begin
    s1_vals <= {value_7, value_6, value_5, value_4,
                value_3, value_2, value_1, value_0};
  end

  msel_rank u_rank (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (s1_ctl),
    .in_vals  (s1_vals),
    .sel_vld  (sel_vld),
    .sel      (sel),
    .sel_vals (sel_vals)
  );

  always_comb begin
    med_next = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      med_next = med_next | (sel_vals[i] & {VALUE_BITS{sel[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sel_vld;
    end
  end

  always_ff @(posedge clk) begin
    median_value <= med_next;
  end

  `MSEL_ASSERT_DLY(a_start_to_done, start && !busy, 4, done, "request lost in pipeline")
  `MSEL_ASSERT_IMP(a_done_has_req, done, $past(start, 4), "done without request")
  `MSEL_ASSERT_IMP(a_sel_onehot, sel_vld, $onehot(sel), "rank match not one-hot")

endmodule

[design/msel_rank.sv]
// Rank stages: pairwise compare matrix, then rank count and one-hot pick
module msel_rank
  import msel_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  msel_ctl_t in_ctl,
  input  val_arr_t  in_vals,
  output logic      sel_vld,
  output slot_vec_t sel,
  output val_arr_t  sel_vals
);

  // stage 2 registers
  logic                s2_vld;
  logic [CNT_BITS-1:0] s2_target;
  slot_vec_t           s2_slot_ok;
  rank_mat_t           s2_before;
  val_arr_t            s2_vals;

  rank_mat_t           before_next;
  slot_vec_t           slot_ok_next;
  slot_vec_t           hit_next;

  // before[i][j]: valid slot j sorts ahead of slot i (ties by slot index)
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_ok_next[i] = CNT_BITS'(i) < in_ctl.cnt;
      for (int j = 0; j < MAX_SLOTS; j++) begin
        before_next[i][j] = (CNT_BITS'(j) < in_ctl.cnt) && (j != i) &&
                            ((in_vals[j] < in_vals[i]) ||
                             ((in_vals[j] == in_vals[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= in_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_target  <= in_ctl.cnt >> 1;
    s2_slot_ok <= slot_ok_next;
    s2_before  <= before_next;
    s2_vals    <= in_vals;
  end

  // stage 3: ranks of valid slots are a permutation, so exactly one hits
  always_comb begin
    logic [CNT_BITS-1:0] rank;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      rank = '0;
      for (int j = 0; j < MAX_SLOTS; j++) begin
        rank = rank + CNT_BITS'(s2_before[i][j]);
      end
      hit_next[i] = s2_slot_ok[i] && (rank == s2_target);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_vld <= 1'b0;
    end else begin
      sel_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    sel      <= hit_next;
    sel_vals <= s2_vals;
  end

endmodule
